// ===== rtl/llda_pkg.sv =====
// package: shared types, codes and reset constants of the least-loaded dispatcher
package llda_pkg;

	localparam int MAX_WORKER_SLOTS_DEF = 16;
	localparam int COUNT_BITS_DEF       = 16;

	localparam logic [4:0]  MIN_WORKERS_RST  = 5'd1;
	localparam logic [4:0]  MAX_WORKERS_RST  = 5'd4;
	localparam logic [15:0] SCALE_UP_RST     = 16'd64;
	localparam logic [15:0] SCALE_DOWN_RST   = 16'd8;
	localparam logic [7:0]  DOWN_DELAY_RST   = 8'd30;

	localparam logic [1:0] OP_DISPATCH = 2'd0;
	localparam logic [1:0] OP_CLOSE    = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;
	localparam logic [1:0] OP_SPARE    = 2'd3;

	localparam logic [2:0] REG_MIN_WORKERS = 3'd0;
	localparam logic [2:0] REG_MAX_WORKERS = 3'd1;
	localparam logic [2:0] REG_SCALE_UP    = 3'd2;
	localparam logic [2:0] REG_SCALE_DOWN  = 3'd3;
	localparam logic [2:0] REG_DOWN_DELAY  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TDEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [4:0]  min_workers;
		logic [4:0]  max_workers;
		logic [15:0] scale_up_threshold;
		logic [15:0] scale_down_per_worker;
		logic [7:0]  scale_down_delay;
	} cfg_t;

	typedef struct packed {
		logic [15:0] chosen_worker_id;
		logic        to_main_loop;
		logic [4:0]  worker_total;
		logic [4:0]  draining_total;
	} res_t;

endpackage

// ===== rtl/least_loaded_dispatch_autoscaler_unit.sv =====
// top level: config registers, output register and dispatcher core
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata close_worker_id, s_tuser opcode
//  m_*     | out | m_tvalid/m_tready  | m_tdata id/totals, m_tuser to_main_loop
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// one transaction at a time; each list scan reads one ram entry per cycle.
// close and tick scan the list once (tick then passes through ST_TDEC); dispatch
// scans it again when a draining worker is re-enabled or a worker is appended.
// the ram needs no clearing pass: per-entry valid bits cleared by arst_n.
// a finished result waits in the output register while the next one is worked on.
module least_loaded_dispatch_autoscaler_unit
	import llda_pkg::*;
#(
	parameter int MAX_WORKER_SLOTS = MAX_WORKER_SLOTS_DEF,
	parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // close_worker_id
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // chosen_worker_id, worker_total, draining_total, zero
	output logic [0:0]  m_tuser,  // to_main_loop
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	res_t res, out_q;
	logic res_valid, res_ready, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_workers           <= MIN_WORKERS_RST;
			cfg_q.max_workers           <= MAX_WORKERS_RST;
			cfg_q.scale_up_threshold    <= SCALE_UP_RST;
			cfg_q.scale_down_per_worker <= SCALE_DOWN_RST;
			cfg_q.scale_down_delay      <= DOWN_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_WORKERS: cfg_q.min_workers           <= cfg_data[4:0];
				REG_MAX_WORKERS: cfg_q.max_workers           <= cfg_data[4:0];
				REG_SCALE_UP:    cfg_q.scale_up_threshold    <= cfg_data;
				REG_SCALE_DOWN:  cfg_q.scale_down_per_worker <= cfg_data;
				REG_DOWN_DELAY:  cfg_q.scale_down_delay      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	llda_core #(
		.MAX_WORKER_SLOTS(MAX_WORKER_SLOTS),
		.COUNT_BITS      (COUNT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_cid   (s_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.draining_total, out_q.worker_total, out_q.chosen_worker_id};
	assign m_tuser  = out_q.to_main_loop;

endmodule

// ===== rtl/llda_ram.sv =====
// generic single write port ram with registered read
module llda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/llda_core.sv =====
// sequencer: scans the worker list in ram, picks, grows, compacts and drains
module llda_core
	import llda_pkg::*;
#(
	parameter int MAX_WORKER_SLOTS = MAX_WORKER_SLOTS_DEF,
	parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_op,
	input  logic [15:0] in_cid,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam int SL = MAX_WORKER_SLOTS;
	localparam int CB = COUNT_BITS;
	localparam int IW = (SL > 1) ? $clog2(SL) : 1;
	localparam int LW = $clog2(SL + 1);
	localparam int EW = 17 + CB;
	localparam int TW = CB + LW;
	localparam int CW = TW + 16;
	localparam int PW = LW + 16;
	localparam int MW = (CB > 16) ? CB : 16;
	localparam logic [7:0] SL8 = 8'(SL);

	state_t state_q, state_d;

	logic [LW-1:0] len_q, rd_idx_q, w_q, rem_q, avail_q, nd_q;
	logic [15:0]   next_id_q, cid_q;
	logic [7:0]    low_q;
	logic [SL-1:0] vld_q;
	logic [1:0]    op_q;
	logic          rescan_q, prune_q;
	logic          rd_s1, vrd_s1;
	logic [TW-1:0] total_q;
	logic          sel_found_q, drn_found_q, m_found_q;
	logic          m_drn_q;
	logic [IW-1:0] sel_idx_q, drn_idx_q, m_idx_q;
	logic [CB-1:0] sel_cnt_q, drn_cnt_q, m_cnt_q;
	logic [15:0]   sel_id_q, drn_id_q;
	res_t          res_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	logic [15:0]   ent_id;
	logic [CB-1:0] ent_cnt;
	logic          ent_drn;
	logic [7:0]    mn8, mx8, dly8;
	logic [LW-1:0] mn, mx;
	logic          issue, scan_end, retire, accept, grow_chk, grow_drn, grow_app, restart;
	logic [CW-1:0] prod, tot_w;
	logic          low_cond, fire;
	logic [7:0]    lt_inc;

	llda_ram #(.WIDTH(EW), .DEPTH(SL)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// entries never written read as an idle worker with id zero
	assign ent_drn = vrd_s1 ? rdata[0] : 1'b0;
	assign ent_cnt = vrd_s1 ? rdata[CB:1] : '0;
	assign ent_id  = vrd_s1 ? rdata[CB+16:CB+1] : '0;

	always_comb begin
		mn8 = {3'd0, cfg.min_workers};
		if (mn8 == 8'd0) mn8 = 8'd1;
		if (mn8 > SL8) mn8 = SL8;
		mx8 = {3'd0, cfg.max_workers};
		if (mx8 > SL8) mx8 = SL8;
		if (mx8 < mn8) mx8 = mn8;
		dly8 = (cfg.scale_down_delay == 8'd0) ? 8'd1 : cfg.scale_down_delay;
	end
	assign mn = LW'(mn8);
	assign mx = LW'(mx8);

	assign accept   = (state_q == ST_IDLE) && in_valid;
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q < len_q);
	assign raddr    = rd_idx_q[IW-1:0];
	assign scan_end = (state_q == ST_SCAN) && !rd_s1 && !(rd_idx_q < len_q);
	assign retire   = prune_q && ent_drn && (ent_cnt == '0) && ((len_q - rem_q) > mn);

	assign grow_chk = (op_q == OP_DISPATCH) && !rescan_q && sel_found_q
		&& (MW'(sel_cnt_q) >= MW'(cfg.scale_up_threshold)) && (avail_q < mx);
	assign grow_drn = grow_chk && drn_found_q;
	assign grow_app = grow_chk && !drn_found_q && (len_q < mx);
	assign restart  = scan_end && (grow_drn || grow_app);

	assign prod     = CW'(PW'(avail_q - LW'(1)) * PW'(cfg.scale_down_per_worker));
	assign tot_w    = CW'(total_q);
	assign low_cond = (nd_q == '0) && (avail_q > mn) && (tot_w <= prod);
	assign lt_inc   = low_cond ? ((low_q == 8'hff) ? low_q : low_q + 8'd1) : 8'd0;
	assign fire     = lt_inc >= dly8;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		we       = 1'b0;
		waddr    = w_q[IW-1:0];
		wdata    = {ent_id, ent_cnt, ent_drn};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (rd_s1) begin
					we = prune_q && !retire;
				end else if (scan_end) begin
					case (op_q)
						OP_DISPATCH: begin
							if (grow_drn) begin
								we    = 1'b1;
								waddr = drn_idx_q;
								wdata = {drn_id_q, drn_cnt_q, 1'b0};
							end else if (grow_app) begin
								we    = 1'b1;
								waddr = len_q[IW-1:0];
								wdata = {next_id_q, {CB{1'b0}}, 1'b0};
							end else if (sel_found_q) begin
								we    = 1'b1;
								waddr = sel_idx_q;
								wdata = {sel_id_q,
									(sel_cnt_q == '1) ? sel_cnt_q : sel_cnt_q + CB'(1), 1'b0};
							end
							state_d = restart ? ST_SCAN : ST_DONE;
						end
						OP_CLOSE: begin
							we      = m_found_q && (m_cnt_q != '0);
							waddr   = m_idx_q;
							wdata   = {cid_q, m_cnt_q - CB'(1), m_drn_q};
							state_d = ST_DONE;
						end
						OP_TICK: state_d = ST_TDEC;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_TDEC: begin
				we      = prune_q && fire && sel_found_q;
				waddr   = sel_idx_q;
				wdata   = {sel_id_q, sel_cnt_q, 1'b1};
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LW'(MIN_WORKERS_RST);
			next_id_q <= 16'(MIN_WORKERS_RST);
			low_q     <= '0;
			vld_q     <= '0;
			rd_idx_q  <= '0;
			rd_s1     <= 1'b0;
			rescan_q  <= 1'b0;
			prune_q   <= 1'b0;
			op_q      <= OP_DISPATCH;
		end else begin
			if (we) vld_q[waddr] <= 1'b1;
			rd_s1 <= issue;
			if (issue) rd_idx_q <= rd_idx_q + LW'(1);
			if (accept) begin
				op_q     <= in_op;
				rescan_q <= 1'b0;
				prune_q  <= (in_op == OP_TICK) && (mx > mn);
				rd_idx_q <= '0;
			end
			if (restart) begin
				rescan_q <= 1'b1;
				rd_idx_q <= '0;
				if (grow_drn) begin
					low_q <= '0;
				end else begin
					len_q     <= len_q + LW'(1);
					next_id_q <= next_id_q + 16'd1;
				end
			end
			if (scan_end && prune_q) len_q <= w_q;
			if (state_q == ST_TDEC && prune_q) low_q <= fire ? 8'd0 : lt_inc;
		end
	end

	always_ff @(posedge clk) begin
		vrd_s1 <= vld_q[raddr];
		if (accept || restart) begin
			if (accept) cid_q <= in_cid;
			w_q         <= '0;
			rem_q       <= '0;
			avail_q     <= '0;
			nd_q        <= '0;
			total_q     <= '0;
			sel_found_q <= 1'b0;
			drn_found_q <= 1'b0;
			m_found_q   <= 1'b0;
		end else if (state_q == ST_SCAN && rd_s1) begin
			if (retire) begin
				rem_q <= rem_q + LW'(1);
			end else begin
				w_q <= w_q + LW'(1);
				if (ent_drn) begin
					nd_q <= nd_q + LW'(1);
					if (!drn_found_q) begin
						drn_found_q <= 1'b1;
						drn_idx_q   <= w_q[IW-1:0];
						drn_cnt_q   <= ent_cnt;
						drn_id_q    <= ent_id;
					end
				end else begin
					avail_q <= avail_q + LW'(1);
					total_q <= total_q + TW'(ent_cnt);
					if (!sel_found_q || ent_cnt < sel_cnt_q) begin
						sel_found_q <= 1'b1;
						sel_idx_q   <= w_q[IW-1:0];
						sel_cnt_q   <= ent_cnt;
						sel_id_q    <= ent_id;
					end
				end
				if (!m_found_q && ent_id == cid_q) begin
					m_found_q <= 1'b1;
					m_idx_q   <= w_q[IW-1:0];
					m_cnt_q   <= ent_cnt;
					m_drn_q   <= ent_drn;
				end
			end
		end
		if (scan_end && !restart) begin
			res_q.chosen_worker_id <= (op_q == OP_DISPATCH && sel_found_q) ? sel_id_q : 16'd0;
			res_q.to_main_loop     <= (op_q == OP_DISPATCH) && !sel_found_q;
			res_q.worker_total     <= 5'(prune_q ? w_q : len_q);
			res_q.draining_total   <= 5'(nd_q);
		end
		if (state_q == ST_TDEC) begin
			res_q.draining_total <= 5'(nd_q + LW'(prune_q && fire && sel_found_q));
		end
	end

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(SL)) else $error("list length beyond slots");

	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (32'(avail_q) + 32'(nd_q) <= 32'(len_q)))
		else $error("scan tallies exceed list length");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(restart && grow_app) |=> (len_q == $past(len_q) + LW'(1)))
		else $error("append did not grow the list");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !we)
		else $error("ram write outside a transaction");

endmodule

// ===== tb/tb_top.sv =====
// testbench: least-loaded dispatcher with worker autoscaling, checked against its own predictor
module tb_top;
	import llda_pkg::*;

	localparam int SLOTS = 16;
	localparam int WDOG_LIMIT = 5000;
	localparam int SETTLE = 60;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] id;
		logic        typed;
		res_t        r;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_DISPATCH;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_MIN_WORKERS;
	logic [15:0] cfg_data = '0;

	// predictor state
	logic [4:0]  c_min = MIN_WORKERS_RST;
	logic [4:0]  c_max = MAX_WORKERS_RST;
	logic [15:0] c_thr = SCALE_UP_RST;
	logic [15:0] c_down = SCALE_DOWN_RST;
	logic [7:0]  c_delay = DOWN_DELAY_RST;
	logic [15:0] ids [SLOTS];
	logic [15:0] cnts [SLOTS];
	logic        drn [SLOTS];
	int          wlen;
	logic [15:0] next_id;
	int          low_ticks;

	res_t        expected_q [$];
	int          errors = 0;
	int          mode = 0;
	int          idle_cnt = 0;

	least_loaded_dispatch_autoscaler_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_min();
		int m;
		m = c_min;
		if (m < 1) m = 1;
		if (m > SLOTS) m = SLOTS;
		return m;
	endfunction

	function automatic int eff_max();
		int x;
		x = c_max;
		if (x > SLOTS) x = SLOTS;
		if (x < eff_min()) x = eff_min();
		return x;
	endfunction

	function automatic int least_loaded();
		int sel;
		longint best;
		sel = -1;
		best = 64'h7fffffff;
		for (int i = 0; i < wlen; i++)
			if (!drn[i] && cnts[i] < best) begin
				sel = i;
				best = cnts[i];
			end
		return sel;
	endfunction

	function automatic void list_reset();
		wlen = eff_min();
		for (int i = 0; i < SLOTS; i++) begin
			ids[i] = (i < wlen) ? i[15:0] : '0;
			cnts[i] = '0;
			drn[i] = 1'b0;
		end
		next_id = wlen[15:0];
		low_ticks = 0;
	endfunction

	function automatic void dispatch(ref res_t r);
		int sel, avail, dr;
		sel = least_loaded();
		avail = 0;
		for (int i = 0; i < wlen; i++)
			if (!drn[i]) avail++;
		if (sel >= 0 && cnts[sel] >= c_thr && avail < eff_max()) begin
			dr = -1;
			for (int i = 0; i < wlen; i++)
				if (drn[i] && dr < 0) dr = i;
			if (dr >= 0) begin
				drn[dr] = 1'b0;
				low_ticks = 0;
			end else if (wlen < eff_max()) begin
				ids[wlen] = next_id;
				cnts[wlen] = '0;
				drn[wlen] = 1'b0;
				wlen++;
				next_id = next_id + 16'd1;
			end
			sel = least_loaded();
		end
		if (sel < 0) begin
			r.to_main_loop = 1'b1;
		end else begin
			if (cnts[sel] != 16'hffff) cnts[sel] = cnts[sel] + 16'd1;
			r.chosen_worker_id = ids[sel];
		end
	endfunction

	function automatic void close_conn(logic [15:0] cid);
		for (int i = 0; i < wlen; i++)
			if (ids[i] == cid) begin
				if (cnts[i] != 0) cnts[i] = cnts[i] - 16'd1;
				return;
			end
	endfunction

	function automatic void tick();
		int mn, w, avail, dl, cand;
		bit any_drain;
		longint total;
		mn = eff_min();
		if (eff_max() <= mn) return;
		w = 0;
		for (int i = 0; i < wlen; i++) begin
			if (drn[i] && cnts[i] == 0 && (wlen - (i - w)) > mn) continue;
			ids[w] = ids[i];
			cnts[w] = cnts[i];
			drn[w] = drn[i];
			w++;
		end
		wlen = w;
		avail = 0;
		total = 0;
		any_drain = 0;
		for (int i = 0; i < wlen; i++)
			if (drn[i]) any_drain = 1;
			else begin
				avail++;
				total += cnts[i];
			end
		if (!any_drain && avail > mn && total <= longint'(avail - 1) * longint'(c_down)) begin
			if (low_ticks < 255) low_ticks++;
		end else begin
			low_ticks = 0;
		end
		dl = (c_delay == 0) ? 1 : c_delay;
		if (low_ticks >= dl) begin
			cand = least_loaded();
			if (cand >= 0) drn[cand] = 1'b1;
			low_ticks = 0;
		end
	endfunction

	function automatic res_t predict_step(logic [1:0] op, logic [15:0] cid);
		res_t r;
		int nd;
		r = '0;
		case (op)
			OP_DISPATCH: dispatch(r);
			OP_CLOSE:    close_conn(cid);
			OP_TICK:     tick();
			default:     ;
		endcase
		nd = 0;
		for (int i = 0; i < wlen; i++)
			if (drn[i]) nd++;
		r.worker_total = wlen[4:0];
		r.draining_total = nd[4:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic int send_idle_pct();
		return (mode == 1) ? 74 : (mode == 3) ? 29 : 0;
	endfunction

	function automatic int recv_stall_pct();
		return (mode == 2) ? 74 : (mode == 3) ? 29 : 0;
	endfunction

	// returns the prediction for the accepted transaction
	task automatic send(logic [1:0] op, logic [15:0] cid, output res_t r);
		while ($urandom_range(0, 99) < send_idle_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cid;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		r = predict_step(op, cid);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MIN_WORKERS: c_min = val[4:0];
			REG_MAX_WORKERS: c_max = val[4:0];
			REG_SCALE_UP:    c_thr = val;
			REG_SCALE_DOWN:  c_down = val;
			REG_DOWN_DELAY:  c_delay = val[7:0];
			default:         ;
		endcase
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly dispatches and closes of live ids, ticks often enough to scale down
	task automatic random_items(int n);
		logic [1:0]  op;
		logic [15:0] cid;
		int          k;
		res_t        r;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(0, 99);
			op = (k < 42) ? OP_DISPATCH : (k < 70) ? OP_CLOSE : (k < 95) ? OP_TICK : OP_SPARE;
			if (wlen > 0 && $urandom_range(0, 3) != 0)
				cid = ids[$urandom_range(0, wlen - 1)];
			else
				cid = 16'($urandom);
			send(op, cid, r);
			expected_q = {expected_q, r};
		end
	endtask

	localparam dir_row_t DIR_ROWS [14] = '{
		{OP_DISPATCH, 16'h0000, 1'b1, 16'd0, 1'b0, 5'd1, 5'd0},
		{OP_CLOSE,    16'h0000, 1'b1, 16'd0, 1'b0, 5'd1, 5'd0},
		{OP_CLOSE,    16'h0000, 1'b1, 16'd0, 1'b0, 5'd1, 5'd0},
		{OP_CLOSE,    16'hffff, 1'b1, 16'd0, 1'b0, 5'd1, 5'd0},
		{OP_SPARE,    16'hffff, 1'b1, 16'd0, 1'b0, 5'd1, 5'd0},
		{OP_TICK,     16'h0000, 1'b1, 16'd0, 1'b0, 5'd1, 5'd0},
		{OP_DISPATCH, 16'haaaa, 1'b0, 27'd0},
		{OP_DISPATCH, 16'h5555, 1'b0, 27'd0},
		{OP_CLOSE,    16'haaaa, 1'b0, 27'd0},
		{OP_CLOSE,    16'h5555, 1'b0, 27'd0},
		{OP_TICK,     16'hffff, 1'b0, 27'd0},
		{OP_DISPATCH, 16'h0000, 1'b0, 27'd0},
		{OP_SPARE,    16'h0000, 1'b0, 27'd0},
		{OP_DISPATCH, 16'h0000, 1'b0, 27'd0}
	};

	localparam int NPH = 8;
	localparam logic [15:0] PH_CFG [NPH][5] = '{
		'{16'd1,  16'd4,  16'd2,     16'd8,     16'd3},
		'{16'd0,  16'd31, 16'd1,     16'd65535, 16'd1},
		'{16'd2,  16'd16, 16'd65535, 16'd0,     16'd0},
		'{16'd16, 16'd16, 16'd1,     16'd8,     16'd30},
		'{16'd31, 16'd5,  16'd3,     16'd100,   16'd255},
		'{16'd3,  16'd2,  16'd1,     16'd65535, 16'd2},
		'{16'd1,  16'd16, 16'd4,     16'd65535, 16'd1},
		'{16'd1,  16'd8,  16'd10,    16'd3,     16'd5}
	};

	// result checker and receiver stalls
	always @(posedge clk) begin
		res_t want;
		if (m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[15:0] != want.chosen_worker_id)
					report_mismatch("chosen_worker_id", m_tdata[15:0], want.chosen_worker_id);
				if (m_tuser[0] != want.to_main_loop)
					report_mismatch("to_main_loop", m_tuser[0], want.to_main_loop);
				if (m_tdata[20:16] != want.worker_total)
					report_mismatch("worker_total", m_tdata[20:16], want.worker_total);
				if (m_tdata[25:21] != want.draining_total)
					report_mismatch("draining_total", m_tdata[25:21], want.draining_total);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		res_t r;
		list_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIR_ROWS[i]) begin
			send(DIR_ROWS[i].op, DIR_ROWS[i].id, r);
			expected_q = {expected_q, (DIR_ROWS[i].typed ? DIR_ROWS[i].r : r)};
		end
		random_items(100);
		for (int p = 0; p < NPH; p++) begin
			drain_and_settle();
			for (int k = 0; k < 5; k++)
				write_reg(k[2:0], PH_CFG[p][k]);
			cfg_we <= 1'b0;
			mode = p % 4;
			random_items(140);
		end
		drain_and_settle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
